// File: rtl/seven_segment_two_wire_writer_top_macros.svh
// assertion macros for the two-wire segment display writer
// used by the checker; no other dependencies
`ifndef SEVEN_SEGMENT_TWO_WIRE_WRITER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_TWO_WIRE_WRITER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SSTW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sstw check failed: same-cycle property");

// consequent must hold in the cycle after the antecedent
`define SSTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sstw check failed: next-cycle property");

`endif

// File: rtl/sstw_pkg.sv
// shared types and constants for the two-wire segment display writer
// no dependencies
package sstw_pkg;

  localparam int SEG_W       = 8;
  localparam int BRIGHT_W    = 3;
  localparam int TPQ_W       = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int INPUT_DIGITS = 4;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKS      = 2'd1;

  // item action codes
  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_LOAD = 1'b1;

  // display protocol commands
  localparam logic [SEG_W-1:0] CMD_DATA    = 8'h40;
  localparam logic [SEG_W-1:0] CMD_ADDR    = 8'hC0;
  localparam logic [SEG_W-1:0] CMD_DISPLAY = 8'h88;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_START_C,
    PH_BIT_A,
    PH_BIT_B,
    PH_BIT_C,
    PH_ACK_A,
    PH_ACK_B,
    PH_STOP_A,
    PH_STOP_B,
    PH_STOP_C,
    PH_STOP_D
  } phase_t;

  typedef struct packed {
    logic             action;
    logic [SEG_W-1:0] digit0_segments;
    logic [SEG_W-1:0] digit1_segments;
    logic [SEG_W-1:0] digit2_segments;
    logic [SEG_W-1:0] digit3_segments;
  } item_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0] brightness;
    logic [TPQ_W-1:0]    ticks_per_quantum;
  } cfg_t;

  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic data_released;
    logic busy_res;
    logic update_done;
  } result_t;

endpackage

// File: rtl/sstw_if.sv
// channel interfaces for the two-wire segment display writer
// depends on sstw_pkg for field widths
interface sstw_item_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [sstw_pkg::SEG_W-1:0] digit0_segments;
  logic [sstw_pkg::SEG_W-1:0] digit1_segments;
  logic [sstw_pkg::SEG_W-1:0] digit2_segments;
  logic [sstw_pkg::SEG_W-1:0] digit3_segments;

  modport source (output valid, action, digit0_segments, digit1_segments,
                  digit2_segments, digit3_segments, input ready);
  modport sink (input valid, action, digit0_segments, digit1_segments,
                digit2_segments, digit3_segments, output ready);
endinterface

interface sstw_result_if;
  logic valid;
  logic ready;
  logic clock_level;
  logic data_level;
  logic data_released;
  logic busy_res;
  logic update_done;

  modport source (output valid, clock_level, data_level, data_released, busy_res,
                  update_done, input ready);
  modport sink (input valid, clock_level, data_level, data_released, busy_res,
                update_done, output ready);
endinterface

interface sstw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sstw_pkg::CFG_INDEX_W-1:0] index;
  logic [sstw_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/sstw_seq.sv
// waveform sequencer: holds the update state and computes one result per item
// depends on sstw_pkg
module sstw_seq #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  sstw_pkg::item_t   item,
  input  sstw_pkg::cfg_t    cfg,
  output sstw_pkg::result_t result
);
  import sstw_pkg::*;

  localparam int BYTE_W   = $clog2(DIGIT_COUNT + 3);
  localparam int LATCH_N  = (DIGIT_COUNT < INPUT_DIGITS) ? DIGIT_COUNT : INPUT_DIGITS;
  localparam logic [BYTE_W-1:0] LAST_BYTE  = BYTE_W'(DIGIT_COUNT + 2);
  localparam logic [BYTE_W-1:0] LAST_DIGIT = BYTE_W'(DIGIT_COUNT + 1);

  logic [SEG_W-1:0]  seg [LATCH_N];
  logic [SEG_W-1:0]  seg_in [INPUT_DIGITS];
  logic [SEG_W-1:0]  shift_byte, shift_byte_next;
  logic [3:0]        bit_index, bit_index_next, bit_index_inc;
  logic [BYTE_W-1:0] byte_index, byte_index_next, byte_index_inc, digit_slot;
  phase_t            phase, phase_next, target;
  logic [1:0]        wait_quanta, wait_quanta_next, wait_dec;
  logic [TPQ_W-1:0]  quantum_divider, quantum_divider_next, limit;
  logic [TPQ_W:0]    divider_inc;
  logic              clk_pin, clk_pin_next;
  logic              dio_pin, dio_pin_next;
  logic              dio_rel, dio_rel_next;
  logic              do_enter, done, do_load;
  logic [SEG_W-1:0]  following_byte;

  assign seg_in[0] = item.digit0_segments;
  assign seg_in[1] = item.digit1_segments;
  assign seg_in[2] = item.digit2_segments;
  assign seg_in[3] = item.digit3_segments;

  assign byte_index_inc = byte_index + BYTE_W'(1);
  assign bit_index_inc  = bit_index + 4'd1;
  assign digit_slot     = byte_index_inc - BYTE_W'(2);
  assign limit          = (cfg.ticks_per_quantum == '0) ? TPQ_W'(1) : cfg.ticks_per_quantum;
  assign divider_inc    = {1'b0, quantum_divider} + (TPQ_W + 1)'(1);
  assign wait_dec       = (wait_quanta != 2'd0) ? wait_quanta - 2'd1 : wait_quanta;
  assign do_load        = accept && (item.action == ACTION_LOAD) && (phase == PH_IDLE);

  // byte sent after the current one: command, segment byte or display control
  always_comb begin
    following_byte = '0;
    if (byte_index_inc == BYTE_W'(1)) begin
      following_byte = CMD_ADDR;
    end else if (byte_index_inc >= LAST_BYTE) begin
      following_byte = CMD_DISPLAY | {{(SEG_W-BRIGHT_W){1'b0}}, cfg.brightness};
    end else begin
      for (int i = 0; i < LATCH_N; i++) begin
        if (digit_slot == BYTE_W'(i)) following_byte = seg[i];
      end
    end
  end

  // step advance: counts ticks into quanta and picks the next phase
  always_comb begin
    phase_next           = phase;
    shift_byte_next      = shift_byte;
    bit_index_next       = bit_index;
    byte_index_next      = byte_index;
    wait_quanta_next     = wait_quanta;
    quantum_divider_next = quantum_divider;
    do_enter             = 1'b0;
    done                 = 1'b0;
    target               = PH_IDLE;
    if (accept) begin
      if (item.action == ACTION_LOAD) begin
        if (phase == PH_IDLE) begin
          byte_index_next = '0;
          shift_byte_next = CMD_DATA;
          bit_index_next  = '0;
          do_enter        = 1'b1;
          target          = PH_START_A;
        end
      end else if (phase != PH_IDLE) begin
        if (divider_inc >= {1'b0, limit}) begin
          quantum_divider_next = '0;
          wait_quanta_next     = wait_dec;
          if (wait_dec == 2'd0) begin
            do_enter = 1'b1;
            unique case (phase)
              PH_START_A: target = PH_START_B;
              PH_START_B: target = PH_START_C;
              PH_START_C: target = PH_BIT_A;
              PH_BIT_A:   target = PH_BIT_B;
              PH_BIT_B:   target = PH_BIT_C;
              PH_BIT_C: begin
                shift_byte_next = shift_byte >> 1;
                bit_index_next  = bit_index_inc;
                target          = (bit_index_inc >= 4'd8) ? PH_ACK_A : PH_BIT_A;
              end
              PH_ACK_A:   target = PH_ACK_B;
              PH_ACK_B: begin
                if (byte_index == '0 || byte_index >= LAST_DIGIT) begin
                  target = PH_STOP_A;
                end else begin
                  byte_index_next = byte_index_inc;
                  shift_byte_next = following_byte;
                  bit_index_next  = '0;
                  target          = PH_BIT_A;
                end
              end
              PH_STOP_A:  target = PH_STOP_B;
              PH_STOP_B:  target = PH_STOP_C;
              PH_STOP_C:  target = PH_STOP_D;
              PH_STOP_D: begin
                if (byte_index >= LAST_BYTE) begin
                  do_enter         = 1'b0;
                  phase_next       = PH_IDLE;
                  wait_quanta_next = 2'd0;
                  done             = 1'b1;
                end else begin
                  byte_index_next = byte_index_inc;
                  shift_byte_next = following_byte;
                  bit_index_next  = '0;
                  target          = PH_START_A;
                end
              end
              default: begin
                do_enter   = 1'b0;
                phase_next = PH_IDLE;
              end
            endcase
          end
        end else begin
          quantum_divider_next = divider_inc[TPQ_W-1:0];
        end
      end
    end
  end

  // pin levels set on entry to a phase
  always_comb begin
    clk_pin_next = clk_pin;
    dio_pin_next = dio_pin;
    dio_rel_next = dio_rel;
    if (do_enter) begin
      unique case (target)
        PH_START_A: begin
          clk_pin_next = 1'b1;
          dio_pin_next = 1'b1;
          dio_rel_next = 1'b0;
        end
        PH_START_B: dio_pin_next = 1'b0;
        PH_START_C: clk_pin_next = 1'b0;
        PH_BIT_A: begin
          clk_pin_next = 1'b0;
          dio_rel_next = 1'b0;
        end
        PH_BIT_B:   dio_pin_next = shift_byte_next[0];
        PH_BIT_C:   clk_pin_next = 1'b1;
        PH_ACK_A: begin
          clk_pin_next = 1'b0;
          dio_rel_next = 1'b1;
          dio_pin_next = 1'b1;
        end
        PH_ACK_B:   clk_pin_next = 1'b1;
        PH_STOP_A: begin
          clk_pin_next = 1'b0;
          dio_rel_next = 1'b0;
        end
        PH_STOP_B:  dio_pin_next = 1'b0;
        PH_STOP_C:  clk_pin_next = 1'b1;
        PH_STOP_D:  dio_pin_next = 1'b1;
        default: ;
      endcase
    end
  end

  // phase entry resets the divider and sets the step length
  logic [1:0]       wait_final;
  logic [TPQ_W-1:0] divider_final;
  phase_t           phase_final;
  always_comb begin
    wait_final    = wait_quanta_next;
    divider_final = quantum_divider_next;
    phase_final   = phase_next;
    if (do_enter) begin
      phase_final   = target;
      divider_final = '0;
      wait_final    = (target == PH_BIT_C || target == PH_ACK_B) ? 2'd2 : 2'd1;
    end else if (done) begin
      divider_final = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      shift_byte      <= '0;
      bit_index       <= '0;
      byte_index      <= '0;
      wait_quanta     <= '0;
      quantum_divider <= '0;
      clk_pin         <= 1'b1;
      dio_pin         <= 1'b1;
      dio_rel         <= 1'b0;
    end else if (accept) begin
      phase           <= phase_final;
      shift_byte      <= shift_byte_next;
      bit_index       <= bit_index_next;
      byte_index      <= byte_index_next;
      wait_quanta     <= wait_final;
      quantum_divider <= divider_final;
      clk_pin         <= clk_pin_next;
      dio_pin         <= dio_pin_next;
      dio_rel         <= dio_rel_next;
    end
  end

  // segment latch, written on a load while idle
  always_ff @(posedge clk) begin
    if (do_load) begin
      for (int i = 0; i < LATCH_N; i++) seg[i] <= seg_in[i];
    end
  end

  // result for this item
  always_comb begin
    result.clock_level   = clk_pin_next;
    result.data_level    = dio_rel_next | dio_pin_next;
    result.data_released = dio_rel_next;
    result.busy_res      = (phase_final != PH_IDLE);
    result.update_done   = done;
  end

endmodule

// File: rtl/seven_segment_two_wire_writer_top.sv
// Two-wire seven-segment display writer, top level.
// Channels: item (sink) carries action and four segment bytes; result
// (source) carries clock_level, data_level, data_released, busy_res and
// update_done; cfg (sink) writes brightness (index 0) and
// ticks_per_quantum (index 1) and is always ready.
// A load item while idle latches the segment bytes and starts an update of
// three frames; each tick item then counts one tick toward the next step.
// A load while busy and a tick while idle leave the state unchanged.
// Every item gives exactly one result, in the cycle after its transfer, from
// the result register. Unless the receiver stalls, throughput is one item
// per cycle: the sequencer's next-state logic is a single pass between state
// and result registers. The item channel stays ready while the result
// register is empty or is being taken; when the receiver stalls, one result
// waits and item ready drops until it is taken. Reset is synchronous: the
// sequencer goes idle with clock and data driven high, the result register
// empties, and the registers return to brightness 7 and one tick per quantum.
// depends on sstw_pkg, sstw_if and sstw_seq
module seven_segment_two_wire_writer_top #(
  parameter int DIGIT_COUNT = 4
) (
  input logic         clk,
  input logic         rst,
  sstw_item_if.sink   item,
  sstw_result_if.source result,
  sstw_cfg_if.sink    cfg
);
  import sstw_pkg::*;

  logic    accept;
  logic    result_valid;
  item_t   item_data;
  cfg_t    cfg_regs;
  result_t step_result;
  result_t result_reg;

  // input side may move whenever the result register can take a new value
  assign item.ready = !result_valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  assign item_data.action          = item.action;
  assign item_data.digit0_segments = item.digit0_segments;
  assign item_data.digit1_segments = item.digit1_segments;
  assign item_data.digit2_segments = item.digit2_segments;
  assign item_data.digit3_segments = item.digit3_segments;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.brightness        <= BRIGHT_W'(7);
      cfg_regs.ticks_per_quantum <= TPQ_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_BRIGHTNESS) begin
        cfg_regs.brightness <= cfg.data[BRIGHT_W-1:0];
      end else if (cfg.index == REG_TICKS) begin
        cfg_regs.ticks_per_quantum <= cfg.data[TPQ_W-1:0];
      end
    end
  end

  sstw_seq #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item_data),
    .cfg    (cfg_regs),
    .result (step_result)
  );

  // result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result_reg <= step_result;
    end
  end

  assign result.valid         = result_valid;
  assign result.clock_level   = result_reg.clock_level;
  assign result.data_level    = result_reg.data_level;
  assign result.data_released = result_reg.data_released;
  assign result.busy_res      = result_reg.busy_res;
  assign result.update_done   = result_reg.update_done;

endmodule

// File: rtl/sstw_checker.sv
// port-level checks for the two-wire segment display writer, bound to the top
// depends on seven_segment_two_wire_writer_top_macros.svh
`include "seven_segment_two_wire_writer_top_macros.svh"

module sstw_checker (
  input logic clk,
  input logic rst,
  input logic result_valid,
  input logic result_ready,
  input logic clock_level,
  input logic data_level,
  input logic data_released,
  input logic busy_res,
  input logic update_done
);

  logic [4:0] pins;
  logic       bus_rest;
  logic       stalled;

  assign pins     = {clock_level, data_level, data_released, busy_res, update_done};
  assign bus_rest = !busy_res && clock_level && data_level;
  assign stalled  = result_valid && !result_ready;

  // a released data pin reads high and only happens during an update
  `SSTW_ASSERT_NOW(a_release_high, clk, rst, result_valid && data_released, data_level && busy_res)

  // the done pulse marks the return to idle with the bus at rest
  `SSTW_ASSERT_NOW(a_done_idle, clk, rst, result_valid && update_done, bus_rest)

  // the result register is empty right after reset
  `SSTW_ASSERT_NOW(a_reset_empty, clk, rst, $fell(rst), !result_valid)

  // a stalled result holds
  `SSTW_ASSERT_NEXT(a_stall_hold, clk, rst, stalled, result_valid && $stable(pins))

endmodule

bind seven_segment_two_wire_writer_top sstw_checker u_sstw_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .clock_level   (result.clock_level),
  .data_level    (result.data_level),
  .data_released (result.data_released),
  .busy_res      (result.busy_res),
  .update_done   (result.update_done)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the two-wire seven-segment display writer
// drives load and tick items, predicts every pin result and compares
// depends on sstw_pkg, sstw_if and seven_segment_two_wire_writer_top
module testbench;
  import sstw_pkg::*;

  localparam int DIGITS = 4;
  localparam int LAST_BYTE = DIGITS + 2;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int PRINT_CAP = 50;
  localparam int PHASE_ITEMS = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sstw_item_if item_ch ();
  sstw_result_if result_ch ();
  sstw_cfg_if cfg_ch ();

  seven_segment_two_wire_writer_top #(.DIGIT_COUNT(DIGITS)) dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  // pending stimulus and expected pin results
  item_t pending_items[$];
  result_t expected_pins[$];

  // sender and receiver bookkeeping
  item_t offered;
  bit offering = 1'b0;
  bit taken = 1'b0;
  bit idling_on = 1'b1;
  int sender_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int error_count = 0;
  int results_seen = 0;
  int cycle_count = 0;

  // predicted configuration, at reset values
  logic [BRIGHT_W-1:0] bright_cfg = 3'd7;
  logic [TPQ_W-1:0] ticks_cfg = 10'd1;

  // predicted sequencer state, at reset values
  logic [SEG_W-1:0] seg_latch [DIGITS];
  logic [SEG_W-1:0] shifter = '0;
  logic [3:0] bit_count = '0;
  logic [2:0] byte_count = '0;
  phase_t seq_phase = PH_IDLE;
  logic [1:0] quanta_left = '0;
  logic [TPQ_W-1:0] divider = '0;
  logic clk_lvl = 1'b1;
  logic dio_lvl = 1'b1;
  logic dio_in = 1'b0;

  always #1 clk = ~clk;

  // byte to shift out next: commands around the latched segments
  function automatic void load_next_byte();
    if (byte_count == 0)
      shifter = CMD_DATA;
    else if (byte_count == 1)
      shifter = CMD_ADDR;
    else if (byte_count >= LAST_BYTE)
      shifter = CMD_DISPLAY | SEG_W'(bright_cfg);
    else
      shifter = seg_latch[(int'(byte_count) - 2) % DIGITS];
    bit_count = '0;
  endfunction

  // step entry sets the pin levels and the wait length
  function automatic void enter_phase(phase_t ph);
    seq_phase = ph;
    divider = '0;
    quanta_left = 2'd1;
    case (ph)
      PH_START_A: begin
        clk_lvl = 1'b1;
        dio_lvl = 1'b1;
        dio_in = 1'b0;
      end
      PH_START_B: dio_lvl = 1'b0;
      PH_START_C: clk_lvl = 1'b0;
      PH_BIT_A: begin
        clk_lvl = 1'b0;
        dio_in = 1'b0;
      end
      PH_BIT_B: dio_lvl = shifter[0];
      PH_BIT_C: begin
        clk_lvl = 1'b1;
        quanta_left = 2'd2;
      end
      PH_ACK_A: begin
        clk_lvl = 1'b0;
        dio_in = 1'b1;
        dio_lvl = 1'b1;
      end
      PH_ACK_B: begin
        clk_lvl = 1'b1;
        quanta_left = 2'd2;
      end
      PH_STOP_A: begin
        clk_lvl = 1'b0;
        dio_in = 1'b0;
      end
      PH_STOP_B: dio_lvl = 1'b0;
      PH_STOP_C: clk_lvl = 1'b1;
      PH_STOP_D: dio_lvl = 1'b1;
      default: begin
        seq_phase = PH_IDLE;
        quanta_left = '0;
      end
    endcase
  endfunction

  // pin result of one item, advancing the predicted sequencer
  function automatic result_t predict_pins(item_t it);
    logic [SEG_W-1:0] digs [INPUT_DIGITS];
    logic [TPQ_W-1:0] lim;
    logic done;
    result_t r;
    digs[0] = it.digit0_segments;
    digs[1] = it.digit1_segments;
    digs[2] = it.digit2_segments;
    digs[3] = it.digit3_segments;
    done = 1'b0;
    if (it.action == ACTION_LOAD) begin
      // load only starts an update from idle
      if (seq_phase == PH_IDLE) begin
        for (int i = 0; i < DIGITS; i++)
          seg_latch[i] = (i < INPUT_DIGITS) ? digs[i] : '0;
        byte_count = '0;
        load_next_byte();
        enter_phase(PH_START_A);
      end
    end else if (seq_phase != PH_IDLE) begin
      lim = (ticks_cfg == 0) ? TPQ_W'(1) : ticks_cfg;
      divider = divider + 1'b1;
      if (divider >= lim) begin
        divider = '0;
        if (quanta_left > 0) quanta_left = quanta_left - 1'b1;
        if (quanta_left == 0) begin
          case (seq_phase)
            // plain steps move to the following one
            PH_START_A, PH_START_B, PH_START_C, PH_BIT_A, PH_BIT_B, PH_ACK_A,
            PH_STOP_A, PH_STOP_B, PH_STOP_C: begin
              enter_phase(phase_t'(seq_phase + 1));
            end
            PH_BIT_C: begin
              shifter = shifter >> 1;
              bit_count = bit_count + 1'b1;
              enter_phase(bit_count >= 8 ? PH_ACK_A : PH_BIT_A);
            end
            // the data frame runs on through the segment bytes
            PH_ACK_B: begin
              if (byte_count == 0 || byte_count >= DIGITS + 1) begin
                enter_phase(PH_STOP_A);
              end else begin
                byte_count = byte_count + 1'b1;
                load_next_byte();
                enter_phase(PH_BIT_A);
              end
            end
            PH_STOP_D: begin
              if (byte_count >= LAST_BYTE) begin
                seq_phase = PH_IDLE;
                quanta_left = '0;
                divider = '0;
                done = 1'b1;
              end else begin
                byte_count = byte_count + 1'b1;
                load_next_byte();
                enter_phase(PH_START_A);
              end
            end
            default: seq_phase = PH_IDLE;
          endcase
        end
      end
    end
    r.clock_level = clk_lvl;
    r.data_level = dio_in ? 1'b1 : dio_lvl;
    r.data_released = dio_in;
    r.busy_res = (seq_phase != PH_IDLE);
    r.update_done = done;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %b expected %b",
                                results_seen, name, got, want));
  endtask

  function automatic item_t tick_item();
    logic [63:0] raw;
    item_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.action = ACTION_TICK;
    return it;
  endfunction

  function automatic item_t load_item(input logic [SEG_W-1:0] d0, d1, d2, d3);
    item_t it;
    it.action = ACTION_LOAD;
    it.digit0_segments = d0;
    it.digit1_segments = d1;
    it.digit2_segments = d2;
    it.digit3_segments = d3;
    return it;
  endfunction

  function automatic item_t random_load();
    return load_item(SEG_W'($urandom), SEG_W'($urandom), SEG_W'($urandom), SEG_W'($urandom));
  endfunction

  // item driver: holds an offer until its transfer, with random gaps
  always @(negedge clk) begin
    bit show;
    if (!rst) begin
      show = offering && !taken;
      if (!show) begin
        if (sender_gap > 0) begin
          sender_gap--;
        end else if (pending_items.size() > 0) begin
          if (idling_on && $urandom_range(0, 5) == 0) begin
            sender_gap = $urandom_range(0, 7);
          end else begin
            offered = pending_items.pop_front();
            show = 1'b1;
          end
        end
      end
      offering = show;
      taken = 1'b0;
      item_ch.valid <= show;
      item_ch.action <= offered.action;
      item_ch.digit0_segments <= offered.digit0_segments;
      item_ch.digit1_segments <= offered.digit1_segments;
      item_ch.digit2_segments <= offered.digit2_segments;
      item_ch.digit3_segments <= offered.digit3_segments;
    end
  end

  // receiver ready: long hold on request, else random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // item transfers feed the predictor, result transfers are checked
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        expected_pins.push_back(predict_pins(offered));
        taken = 1'b1;
      end
      if (result_ch.valid && result_ch.ready) begin
        got.clock_level = result_ch.clock_level;
        got.data_level = result_ch.data_level;
        got.data_released = result_ch.data_released;
        got.busy_res = result_ch.busy_res;
        got.update_done = result_ch.update_done;
        if (expected_pins.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          want = expected_pins.pop_front();
          check_field("clock_level", got.clock_level, want.clock_level);
          check_field("data_level", got.data_level, want.data_level);
          check_field("data_released", got.data_released, want.data_released);
          check_field("busy_res", got.busy_res, want.busy_res);
          check_field("update_done", got.update_done, want.update_done);
        end
        results_seen++;
      end
    end
  end

  // cycle counter and timeout
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_BRIGHTNESS) bright_cfg = value[BRIGHT_W-1:0];
    else if (idx == REG_TICKS) ticks_cfg = value[TPQ_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // every item transferred and every result back
  task automatic wait_drained();
    while (pending_items.size() != 0 || offering || expected_pins.size() != 0)
      @(posedge clk);
  endtask

  // keep ticking until the running update has ended
  task automatic finish_update();
    wait_drained();
    while (seq_phase != PH_IDLE) begin
      repeat (16) pending_items.push_back(tick_item());
      wait_drained();
    end
  endtask

  // random phase: loads with random bytes and mostly ticks
  task automatic random_phase(input logic [BRIGHT_W-1:0] bright,
                              input logic [TPQ_W-1:0] ticks, input bit idle,
                              input int hold);
    write_register(REG_BRIGHTNESS, CFG_DATA_W'(bright));
    write_register(REG_TICKS, CFG_DATA_W'(ticks));
    @(posedge clk);
    idling_on = idle;
    pending_items.push_back(random_load());
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(0, 49) == 0)
        pending_items.push_back(random_load());
      else
        pending_items.push_back(tick_item());
    end
    hold_left = hold;
    wait_drained();
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.action = ACTION_TICK;
    item_ch.digit0_segments = '0;
    item_ch.digit1_segments = '0;
    item_ch.digit2_segments = '0;
    item_ch.digit3_segments = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_BRIGHTNESS;
    cfg_ch.data = '0;
    offered = load_item('0, '0, '0, '0);
    offered.action = ACTION_TICK;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle ticks, extreme bytes, loads while busy
    pending_items.push_back(tick_item());
    pending_items.push_back(tick_item());
    pending_items.push_back(load_item(8'h00, 8'hFF, 8'hA5, 8'h5A));
    pending_items.push_back(load_item(8'hFF, 8'h00, 8'h5A, 8'hA5));
    repeat (5) pending_items.push_back(tick_item());
    pending_items.push_back(load_item(8'h12, 8'h34, 8'h56, 8'h78));
    finish_update();

    // zero ticks per quantum acts as one, lowest brightness
    write_register(REG_BRIGHTNESS, CFG_DATA_W'(0));
    write_register(REG_TICKS, CFG_DATA_W'(0));
    pending_items.push_back(load_item(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pending_items.push_back(tick_item());
    finish_update();

    // random items at two ticks per quantum with a long receiver hold
    random_phase(3'd5, 10'd2, 1'b1, 60);

    // no idling at the end: one tick per quantum until the update ends
    write_register(REG_BRIGHTNESS, CFG_DATA_W'(3));
    write_register(REG_TICKS, CFG_DATA_W'(1));
    @(posedge clk);
    idling_on = 1'b0;
    pending_items.push_back(tick_item());
    finish_update();
    repeat (10) @(posedge clk);

    if (expected_pins.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_pins.size()));
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
